// ===== sv/pidaw_pkg.sv =====
// Shared types and constants for the PID controller with angle wrap.
package pidaw_pkg;

    // Signed Q16.16 value
    typedef logic signed [31:0] q16_t;

    // Configuration register index
    typedef logic [2:0] cfg_index_t;

    localparam cfg_index_t REG_GAIN_P         = 3'd0;
    localparam cfg_index_t REG_GAIN_I         = 3'd1;
    localparam cfg_index_t REG_GAIN_D         = 3'd2;
    localparam cfg_index_t REG_INTEGRAL_LIMIT = 3'd3;
    localparam cfg_index_t REG_OUTPUT_LIMIT   = 3'd4;
    localparam cfg_index_t REG_ANGLE_MODE     = 3'd5;

    // Fraction bits of the Q16.16 format
    localparam int Q_FRAC = 16;

    // 180 and 360 degrees in Q16.16
    localparam logic signed [31:0] ANGLE_HALF = 32'sd11796480;
    localparam logic signed [31:0] ANGLE_FULL = 32'sd23592960;

    // Product terms are capped in magnitude at 2^TERM_CAP_SHIFT
    localparam int TERM_CAP_SHIFT = 60;

endpackage

// ===== sv/pidaw_ifs.sv =====
// Valid/ready stream interfaces for the sample and result channels.
interface pidaw_in_if;
    import pidaw_pkg::*;

    logic valid;
    logic ready;
    q16_t setpoint;
    q16_t measured;

    modport source (output valid, output setpoint, output measured, input ready);
    modport sink (input valid, input setpoint, input measured, output ready);
endinterface

interface pidaw_out_if;
    import pidaw_pkg::*;

    logic valid;
    logic ready;
    q16_t drive;

    modport source (output valid, output drive, input ready);
    modport sink (input valid, input drive, output ready);
endinterface

// ===== sv/pid_controller_angle_wrap_unit.sv =====
// Top level: pipelined positional PID step with integral clamp and angle wrap.
//
// Usage:
//   sample carries setpoint and measured (signed Q16.16); result carries drive.
//   A transfer happens on a rising edge with valid and ready both high.
//   Gains, limits and angle mode are written through cfg_we/cfg_index/cfg_data
//   while no sample is in flight; an index past angle mode is ignored.
// Timing:
//   Seven-stage pipeline, with one sample taken every cycle while results
//   drain; the drive result is registered at the output stage.
//   The depth is set by the error stages, the split multipliers (two
//   partial products per term), the rounding/cap stages and the final sum.
//   The integral and the previous error are updated in-order as items
//   pass their stage, so dependent steps still run one per cycle.
// Reset:
//   rst_n clears the configuration registers, the integral and previous error
//   to zero and empties the pipeline; the payload registers are not reset.
// Stall:
//   While a result waits and result.ready is low the whole pipeline holds
//   and sample.ready is low; nothing is dropped or repeated.
module pid_controller_angle_wrap_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  pidaw_pkg::cfg_index_t cfg_index,
    input  pidaw_pkg::q16_t       cfg_data,
    pidaw_in_if.sink              sample,
    pidaw_out_if.source           result
);
    import pidaw_pkg::*;

    // Widths derived from the data width
    localparam int DW    = DATA_WIDTH;
    localparam int DX    = DW + 1;                       // error difference
    localparam int SPLIT = DX / 2;                       // low partial width
    localparam int HI_W  = DX - SPLIT;                   // high partial width
    localparam int LO_PW = 32 + SPLIT + 1;
    localparam int HI_PW = 32 + HI_W;
    localparam int PW    = 32 + DX;                      // full product
    localparam int TW    = PW - Q_FRAC;                  // rescaled term
    localparam int CW    = (TW > TERM_CAP_SHIFT + 2) ? TW : TERM_CAP_SHIFT + 2;
    localparam int TCW   = (TW < TERM_CAP_SHIFT + 2) ? TW : TERM_CAP_SHIFT + 2;
    localparam int PDW   = TCW + 1;
    localparam int IW    = ((TCW > 32) ? TCW : 32) + 1;
    localparam int TOW   = ((PDW > 32) ? PDW : 32) + 1;
    localparam int SW    = (DW > 33) ? DW : 33;
    localparam int AW    = (DW > 26) ? DW : 26;
    localparam int OW    = (DW > 32) ? DW : 32;

    localparam logic signed [DW-1:0] DATA_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] DATA_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [AW-1:0] HALF_A   = AW'(ANGLE_HALF);
    localparam logic signed [AW-1:0] FULL_A   = AW'(ANGLE_FULL);
    localparam logic signed [PW-1:0] RND_BIAS = PW'((64'd1 << Q_FRAC) - 64'd1);
    localparam logic signed [PW-1:0] RND_ZERO = '0;
    localparam logic signed [CW-1:0] CAP_POS  = CW'(64'sd1 <<< TERM_CAP_SHIFT);
    localparam logic signed [CW-1:0] CAP_NEG  = -CAP_POS;

    // Term slots
    localparam int NTERM  = 3;
    localparam int TERM_P = 0;
    localparam int TERM_I = 1;
    localparam int TERM_D = 2;

    localparam int NSTAGE = 7;

    // Configuration registers
    q16_t               gain_reg [NTERM];
    logic signed [31:0] ilim_pos_reg;
    logic signed [31:0] ilim_neg_reg;
    logic signed [31:0] olim_pos_reg;
    logic signed [31:0] olim_neg_reg;
    logic               angle_mode_reg;

    // Pipeline control
    logic [NSTAGE-1:0]  valid_reg;
    logic               out_valid_reg;
    logic               advance;

    // Loop state
    logic signed [DW-1:0]  prev_err_reg;
    logic signed [31:0]    isum_reg;
    logic signed [31:0]    isum_next;

    // Pipeline payload
    q16_t                  sp0_reg;
    q16_t                  ms0_reg;
    logic signed [DW-1:0]  err1_reg;
    logic signed [DW-1:0]  err1_next;
    logic signed [DX-1:0]  err2_reg;
    logic signed [DX-1:0]  delta2_reg;
    logic signed [DX-1:0]  delta2_next;
    logic signed [LO_PW-1:0] plo3_reg  [NTERM];
    logic signed [LO_PW-1:0] plo3_next [NTERM];
    logic signed [HI_PW-1:0] phi3_reg  [NTERM];
    logic signed [HI_PW-1:0] phi3_next [NTERM];
    logic [NTERM-1:0]      neg3_reg;
    logic [NTERM-1:0]      neg3_next;
    logic signed [TW-1:0]  term4_reg  [NTERM];
    logic signed [TW-1:0]  term4_next [NTERM];
    logic signed [TCW-1:0] term5_reg  [NTERM];
    logic signed [TCW-1:0] term5_next [NTERM];
    logic signed [PDW-1:0] pd6_reg;
    logic signed [PDW-1:0] pd6_next;
    q16_t                  drive_reg;
    q16_t                  drive_next;

    // Move the whole pipeline whenever the output slot is free or taken
    assign advance      = !out_valid_reg || result.ready;
    assign sample.ready = advance;
    assign result.valid = out_valid_reg;
    assign result.drive = drive_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < NTERM; t++)
            begin
                gain_reg[t] <= '0;
            end
            ilim_pos_reg   <= '0;
            ilim_neg_reg   <= '0;
            olim_pos_reg   <= '0;
            olim_neg_reg   <= '0;
            angle_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN_P: gain_reg[TERM_P] <= cfg_data;
                REG_GAIN_I: gain_reg[TERM_I] <= cfg_data;
                REG_GAIN_D: gain_reg[TERM_D] <= cfg_data;
                REG_INTEGRAL_LIMIT:
                begin
                    ilim_pos_reg <= $signed({1'b0, cfg_data[30:0]});
                    ilim_neg_reg <= -$signed({1'b0, cfg_data[30:0]});
                end
                REG_OUTPUT_LIMIT:
                begin
                    olim_pos_reg <= $signed({1'b0, cfg_data[30:0]});
                    olim_neg_reg <= -$signed({1'b0, cfg_data[30:0]});
                end
                REG_ANGLE_MODE: angle_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Valid shift line and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            prev_err_reg  <= '0;
            isum_reg      <= '0;
        end
        else if (advance)
        begin
            valid_reg     <= {valid_reg[NSTAGE-2:0], sample.valid};
            out_valid_reg <= valid_reg[NSTAGE-1];
            if (valid_reg[1])
            begin
                prev_err_reg <= err1_reg;
            end
            if (valid_reg[5])
            begin
                isum_reg <= isum_next;
            end
        end
    end

    // Stage 1: saturate the error and wrap it in angle mode
    always_comb
    begin
        logic signed [32:0]       diff;
        logic signed [SW-1:0]     diff_ext;
        logic [SW-DW:0]           upper;
        logic signed [DW-1:0]     err_sat;
        logic signed [AW-1:0]     err_a;
        diff     = 33'(sp0_reg) - 33'(ms0_reg);
        diff_ext = SW'(diff);
        upper    = diff_ext[SW-1:DW-1];
        if ((&upper) || !(|upper))
        begin
            err_sat = diff_ext[DW-1:0];
        end
        else
        begin
            err_sat = diff_ext[SW-1] ? DATA_MIN : DATA_MAX;
        end
        err_a = AW'(err_sat);
        if (angle_mode_reg && (err_a > HALF_A))
        begin
            err_a = err_a - FULL_A;
        end
        else if (angle_mode_reg && (err_a < -HALF_A))
        begin
            err_a = err_a + FULL_A;
        end
        err1_next = err_a[DW-1:0];
    end

    // Stage 2: difference against the previous error
    assign delta2_next = DX'(err1_reg) - DX'(prev_err_reg);

    // Stage 3: two partial products per term
    always_comb
    begin
        logic signed [DX-1:0]   opnd;
        logic [SPLIT-1:0]       lo_part;
        logic signed [HI_W-1:0] hi_part;
        for (int t = 0; t < NTERM; t++)
        begin
            opnd         = (t == TERM_D) ? delta2_reg : err2_reg;
            lo_part      = opnd[SPLIT-1:0];
            hi_part      = opnd[DX-1:SPLIT];
            plo3_next[t] = LO_PW'(gain_reg[t]) * LO_PW'($signed({1'b0, lo_part}));
            phi3_next[t] = HI_PW'(gain_reg[t]) * HI_PW'(hi_part);
            neg3_next[t] = gain_reg[t][31] ^ opnd[DX-1];
        end
    end

    // Stage 4: join partials and drop fraction bits toward zero
    always_comb
    begin
        logic signed [PW-1:0] psum;
        for (int t = 0; t < NTERM; t++)
        begin
            psum = $signed({phi3_reg[t], {SPLIT{1'b0}}}) + PW'(plo3_reg[t])
                 + (neg3_reg[t] ? RND_BIAS : RND_ZERO);
            term4_next[t] = psum[PW-1:Q_FRAC];
        end
    end

    // Stage 5: cap each term's magnitude
    always_comb
    begin
        logic signed [CW-1:0] te;
        for (int t = 0; t < NTERM; t++)
        begin
            te = CW'(term4_reg[t]);
            if (te > CAP_POS)
            begin
                te = CAP_POS;
            end
            else if (te < CAP_NEG)
            begin
                te = CAP_NEG;
            end
            term5_next[t] = te[TCW-1:0];
        end
    end

    // Stage 6: accumulate and clamp the integral, add P and D
    always_comb
    begin
        logic signed [IW-1:0] acc;
        acc = IW'(isum_reg) + IW'(term5_reg[TERM_I]);
        if (acc > IW'(ilim_pos_reg))
        begin
            acc = IW'(ilim_pos_reg);
        end
        else if (acc < IW'(ilim_neg_reg))
        begin
            acc = IW'(ilim_neg_reg);
        end
        isum_next = acc[31:0];
        pd6_next  = PDW'(term5_reg[TERM_P]) + PDW'(term5_reg[TERM_D]);
    end

    // Output stage: total, clamp to the output limit, saturate
    always_comb
    begin
        logic signed [TOW-1:0] tot;
        logic signed [OW-1:0]  v_ext;
        logic [OW-DW:0]        upper;
        logic signed [DW-1:0]  satd;
        logic signed [OW-1:0]  sd_ext;
        tot = TOW'(pd6_reg) + TOW'(isum_reg);
        if (tot > TOW'(olim_pos_reg))
        begin
            tot = TOW'(olim_pos_reg);
        end
        else if (tot < TOW'(olim_neg_reg))
        begin
            tot = TOW'(olim_neg_reg);
        end
        v_ext = OW'(tot[31:0]);
        upper = v_ext[OW-1:DW-1];
        if ((&upper) || !(|upper))
        begin
            satd = v_ext[DW-1:0];
        end
        else
        begin
            satd = v_ext[OW-1] ? DATA_MIN : DATA_MAX;
        end
        sd_ext     = OW'(satd);
        drive_next = sd_ext[31:0];
    end

    // Pipeline payload, held while stalled
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sp0_reg    <= sample.setpoint;
            ms0_reg    <= sample.measured;
            err1_reg   <= err1_next;
            err2_reg   <= DX'(err1_reg);
            delta2_reg <= delta2_next;
            for (int t = 0; t < NTERM; t++)
            begin
                plo3_reg[t]  <= plo3_next[t];
                phi3_reg[t]  <= phi3_next[t];
                term4_reg[t] <= term4_next[t];
                term5_reg[t] <= term5_next[t];
            end
            neg3_reg   <= neg3_next;
            pd6_reg    <= pd6_next;
            drive_reg  <= drive_next;
        end
    end

endmodule
